>>> hdl/tgsr_pkg.sv
// shared types, constants and the 5x8 font table of the text glyph stream renderer
package tgsr_pkg;

    localparam int DEF_PAGE_COUNT    = 8;
    localparam int DEF_DISPLAY_WIDTH = 128;
    localparam int QUEUE_DEPTH       = 4;

    localparam int PAGE_W = 4;
    localparam int COL_W  = 8;
    localparam int BYTE_W = 8;
    localparam int GLYPH_IDX_W = 7;
    localparam int STEP_W = 4;

    localparam logic CMD_TEXT       = 1'b0;
    localparam logic CMD_SET_CURSOR = 1'b1;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7F;
    localparam logic [7:0] CHAR_QMARK = 8'h3F;

    localparam logic [7:0] SET_PAGE_BASE = 8'hB0;
    localparam logic [7:0] COL_LO_MASK   = 8'h0F;
    localparam logic [7:0] COL_HI_BASE   = 8'h10;
    localparam logic [7:0] BLANK_COLUMN  = 8'h00;
    localparam int         GLYPH_ADVANCE = 6;

    // byte positions within one job
    localparam logic [STEP_W-1:0] STEP_PAGE    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_COL_LO  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_COL_HI  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_GLYPH_0 = 4'd3;
    localparam logic [STEP_W-1:0] STEP_GLYPH_1 = 4'd4;
    localparam logic [STEP_W-1:0] STEP_GLYPH_2 = 4'd5;
    localparam logic [STEP_W-1:0] STEP_GLYPH_3 = 4'd6;
    localparam logic [STEP_W-1:0] STEP_GLYPH_4 = 4'd7;
    localparam logic [STEP_W-1:0] STEP_BLANK   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SKIP    = 4'd3;

    typedef struct packed {
        logic                   has_move;
        logic                   has_glyph;
        logic [PAGE_W-1:0]      page;
        logic [COL_W-1:0]       column;
        logic [GLYPH_IDX_W-1:0] glyph;
    } t_job;

    // column 0 in the top byte
    localparam logic [39:0] GLYPH_ROM [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
    };

endpackage

>>> hdl/tgsr_front.sv
// front end: accepts text and cursor transactions, tracks the cursor, builds output jobs
module tgsr_front import tgsr_pkg::*; #(
    parameter int PAGE_COUNT    = DEF_PAGE_COUNT,
    parameter int DISPLAY_WIDTH = DEF_DISPLAY_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_command,
    input  logic [7:0]       i_char_code,
    input  logic [3:0]       i_page,
    input  logic [7:0]       i_column,
    input  logic             i_queue_full,
    output logic             o_push,
    output t_job             o_job
);

    localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam logic [PW-1:0]    LAST_PAGE = PW'(PAGE_COUNT - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(DISPLAY_WIDTH - 1);

    logic [PW-1:0]    r_page,   n_page;
    logic [COL_W-1:0] r_column, n_column;

    logic             accept;
    logic [PW-1:0]    next_page;
    logic             wrap;
    logic             printable;

    assign o_ready   = !i_queue_full;
    assign accept    = i_valid && o_ready;
    assign next_page = (r_page == LAST_PAGE) ? r_page : r_page + 1'b1;
    assign wrap      = ({1'b0, r_column} + 9'(GLYPH_ADVANCE)) > 9'(DISPLAY_WIDTH);
    assign printable = (i_char_code >= CHAR_FIRST) && (i_char_code <= CHAR_LAST);

    always_comb begin
        n_page          = r_page;
        n_column        = r_column;
        o_push          = 1'b0;
        o_job.has_move  = 1'b0;
        o_job.has_glyph = 1'b0;
        o_job.page      = PAGE_W'(r_page);
        o_job.column    = '0;
        o_job.glyph     = printable ? GLYPH_IDX_W'(i_char_code - CHAR_FIRST)
                                    : GLYPH_IDX_W'(CHAR_QMARK - CHAR_FIRST);
        if (i_command == CMD_SET_CURSOR) begin
            o_push         = accept;
            o_job.has_move = 1'b1;
            o_job.page     = ({1'b0, i_page} >= 5'(PAGE_COUNT)) ? PAGE_W'(LAST_PAGE) : i_page;
            o_job.column   = ({1'b0, i_column} >= 9'(DISPLAY_WIDTH)) ? LAST_COL : i_column;
            n_page         = PW'(o_job.page);
            n_column       = o_job.column;
        end else begin
            priority case (i_char_code)
                CHAR_NUL: begin
                    o_push = 1'b0;
                end
                CHAR_LF: begin
                    o_push         = accept;
                    o_job.has_move = 1'b1;
                    o_job.page     = PAGE_W'(next_page);
                    n_page         = next_page;
                    n_column       = '0;
                end
                CHAR_CR: begin
                    o_push         = accept;
                    o_job.has_move = 1'b1;
                    n_column       = '0;
                end
                default: begin
                    o_push          = accept;
                    o_job.has_glyph = 1'b1;
                    if (wrap) begin
                        o_job.has_move = 1'b1;
                        o_job.page     = PAGE_W'(next_page);
                        n_page         = next_page;
                        n_column       = COL_W'(GLYPH_ADVANCE);
                    end else begin
                        n_column = r_column + COL_W'(GLYPH_ADVANCE);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page   <= '0;
            r_column <= '0;
        end else if (accept) begin
            r_page   <= n_page;
            r_column <= n_column;
        end
    end

endmodule

>>> hdl/tgsr_queue.sv
// short job queue between the front end and the byte serializer
module tgsr_queue import tgsr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_entry [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/tgsr_back.sv
// back end: jobs into command and data bytes, one per cycle when i_ready
module tgsr_back import tgsr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_control,
    output logic [7:0]  o_out_byte,
    output logic        o_last
);

    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    logic              r_is_control;
    logic [7:0]        r_out_byte;
    logic              r_last;

    logic [STEP_W-1:0] cur;
    logic              advance;
    logic              byte_last;
    logic              byte_ctrl;
    logic [7:0]        byte_val;
    logic [39:0]       glyph_bits;

    assign cur        = i_head.has_move ? r_step : r_step + STEP_SKIP;
    assign advance    = !i_empty && (!r_valid || i_ready);
    assign glyph_bits = GLYPH_ROM[i_head.glyph];
    assign byte_last  = (cur == STEP_BLANK) || ((cur == STEP_COL_HI) && !i_head.has_glyph);
    assign o_pop      = advance && byte_last;

    always_comb begin
        byte_ctrl = 1'b0;
        unique case (cur)
            STEP_PAGE: begin
                byte_ctrl = 1'b1;
                byte_val  = SET_PAGE_BASE | {4'h0, i_head.page};
            end
            STEP_COL_LO: begin
                byte_ctrl = 1'b1;
                byte_val  = i_head.column & COL_LO_MASK;
            end
            STEP_COL_HI: begin
                byte_ctrl = 1'b1;
                byte_val  = COL_HI_BASE | {4'h0, i_head.column[7:4]};
            end
            STEP_GLYPH_0: byte_val = glyph_bits[39:32];
            STEP_GLYPH_1: byte_val = glyph_bits[31:24];
            STEP_GLYPH_2: byte_val = glyph_bits[23:16];
            STEP_GLYPH_3: byte_val = glyph_bits[15:8];
            STEP_GLYPH_4: byte_val = glyph_bits[7:0];
            default:      byte_val = BLANK_COLUMN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (!r_valid || i_ready) begin
                r_valid <= advance;
            end
            if (advance) begin
                r_step <= byte_last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_is_control <= byte_ctrl;
            r_out_byte   <= byte_val;
            r_last       <= byte_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_is_control = r_is_control;
    assign o_out_byte   = r_out_byte;
    assign o_last       = r_last;

endmodule

>>> hdl/text_glyph_stream_renderer.sv
// the first byte of a transaction passes the job queue, then the output register
// throughput: one output byte per cycle while i_ready is high, set by the byte
// serializer: glyph 6 bytes, 9 with a line wrap, cursor move 3, zero byte none
// input is taken whenever the 4-entry job queue has room
// reset: cursor goes to page 0 column 0, queue and output register empty
module text_glyph_stream_renderer import tgsr_pkg::*; #(
    parameter int PAGE_COUNT    = DEF_PAGE_COUNT,
    parameter int DISPLAY_WIDTH = DEF_DISPLAY_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_command,
    input  logic [7:0] i_char_code,
    input  logic [3:0] i_page,
    input  logic [7:0] i_column,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_is_control,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    t_job push_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    tgsr_front #(
        .PAGE_COUNT    (PAGE_COUNT),
        .DISPLAY_WIDTH (DISPLAY_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_page       (i_page),
        .i_column     (i_column),
        .i_queue_full (full),
        .o_push       (push),
        .o_job        (push_job)
    );

    tgsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head_job)
    );

    tgsr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_is_control (o_is_control),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

endmodule

>>> tb/sv/tb.sv
// testbench for text_glyph_stream_renderer: directed and random text, predicted byte stream
module tb;
    import tgsr_pkg::*;

    localparam int NUM_PAGES      = DEF_PAGE_COUNT;
    localparam int PANEL_WIDTH    = DEF_DISPLAY_WIDTH;
    localparam int RANDOM_REQS    = 226;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int QUIET_FROM     = 120;
    localparam int QUIET_TO       = 170;

    // column 0 in the top byte
    localparam logic [39:0] FONT_5X8 [96] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808
    };

    typedef struct {
        logic       command;
        logic [7:0] char_code;
        logic [3:0] page;
        logic [7:0] column;
        bit         wait_for_drain;
    } t_text_req;

    typedef struct {
        logic       is_control;
        logic [7:0] value;
        logic       last;
    } t_panel_byte;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_command   = 1'b0;
    logic [7:0] i_char_code = 8'h00;
    logic [3:0] i_page      = 4'h0;
    logic [7:0] i_column    = 8'h00;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_is_control;
    logic [7:0] o_out_byte;
    logic       o_last;

    t_text_req   pending_reqs[$];
    t_text_req   req_on_bus;
    t_panel_byte expected_bytes[$];
    t_panel_byte want;
    int unsigned cursor_page = 0;
    int unsigned cursor_col  = 0;
    int          accepted_reqs = 0;
    int          total_reqs    = 0;
    int          mismatches    = 0;
    int          stalled_cycles = 0;

    text_glyph_stream_renderer #(
        .PAGE_COUNT   (NUM_PAGES),
        .DISPLAY_WIDTH(PANEL_WIDTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .i_page      (i_page),
        .i_column    (i_column),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_is_control(o_is_control),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit quiet_window();
        return accepted_reqs >= QUIET_FROM && accepted_reqs < QUIET_TO;
    endfunction

    function automatic void add_req(logic cmd, logic [7:0] code, logic [3:0] pg,
                                    logic [7:0] col, bit drain);
        t_text_req r;
        r.command        = cmd;
        r.char_code      = code;
        r.page           = pg;
        r.column         = col;
        r.wait_for_drain = drain;
        pending_reqs.push_back(r);
    endfunction

    // ---------------- byte stream predictor ----------------
    function automatic void emit_byte(logic ctrl, logic [7:0] b);
        t_panel_byte p;
        p.is_control = ctrl;
        p.value      = b;
        p.last       = 1'b0;
        expected_bytes.push_back(p);
    endfunction

    function automatic void move_cursor_to(int unsigned pg, int unsigned col);
        if (pg >= NUM_PAGES) pg = NUM_PAGES - 1;
        if (col >= PANEL_WIDTH) col = PANEL_WIDTH - 1;
        cursor_page = pg;
        cursor_col  = col;
        emit_byte(1'b1, SET_PAGE_BASE | 8'(pg));
        emit_byte(1'b1, 8'(col) & COL_LO_MASK);
        emit_byte(1'b1, COL_HI_BASE | 8'(col >> 4));
    endfunction

    function automatic void render_req(t_text_req r);
        int          n_before;
        logic [7:0]  code;
        logic [39:0] glyph;
        t_panel_byte tail;
        n_before = expected_bytes.size();
        code = r.char_code;
        if (r.command == CMD_SET_CURSOR) begin
            move_cursor_to(r.page, r.column);
        end else if (code == CHAR_LF) begin
            move_cursor_to(cursor_page + 1, 0);
        end else if (code == CHAR_CR) begin
            move_cursor_to(cursor_page, 0);
        end else if (code != CHAR_NUL) begin
            if (code < CHAR_FIRST || code > CHAR_LAST) code = CHAR_QMARK;
            // glyph that does not fit wraps to the next page first
            if (cursor_col + GLYPH_ADVANCE > PANEL_WIDTH) move_cursor_to(cursor_page + 1, 0);
            glyph = FONT_5X8[code - CHAR_FIRST];
            for (int k = 0; k < 5; k++) emit_byte(1'b0, glyph[39 - 8*k -: 8]);
            emit_byte(1'b0, BLANK_COLUMN);
            cursor_col = (cursor_col + GLYPH_ADVANCE) & 8'hFF;
        end
        if (expected_bytes.size() > n_before) begin
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    function automatic void report(string field, logic [7:0] exp_val, logic [7:0] got_val);
        mismatches++;
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, exp_val,
                 got_val);
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                render_req(req_on_bus);
                accepted_reqs++;
            end
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() != 0
                        && (quiet_window() || $urandom_range(99) >= 7)
                        && !(pending_reqs[0].wait_for_drain && expected_bytes.size() != 0)) begin
                    req_on_bus = pending_reqs.pop_front();
                    i_valid     <= 1'b1;
                    i_command   <= req_on_bus.command;
                    i_char_code <= req_on_bus.char_code;
                    i_page      <= req_on_bus.page;
                    i_column    <= req_on_bus.column;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transaction, expected none, actual %0b %02h %0b",
                             $time, o_is_control, o_out_byte, o_last);
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_is_control !== want.is_control)
                        report("is_control", 8'(want.is_control), 8'(o_is_control));
                    if (o_out_byte !== want.value)
                        report("out_byte", want.value, o_out_byte);
                    if (o_last !== want.last)
                        report("last", 8'(want.last), 8'(o_last));
                end
            end
            i_ready <= quiet_window() || ($urandom_range(99) >= 7);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stalled_cycles <= 0;
            end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end else begin
                stalled_cycles <= stalled_cycles + 1;
            end
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        int         pick;
        logic [3:0] pg;
        logic [7:0] col;
        logic [7:0] code;

        // directed: extremes, control codes, clamping and line wraps
        add_req(CMD_TEXT, CHAR_NUL, 4'h0, 8'h00, 0);
        add_req(CMD_TEXT, 8'h41, 4'hF, 8'hFF, 0);
        add_req(CMD_TEXT, CHAR_FIRST, 4'h0, 8'h00, 0);
        add_req(CMD_TEXT, CHAR_LAST, 4'h5, 8'hA5, 0);
        add_req(CMD_TEXT, 8'h01, 4'h0, 8'h00, 0);
        add_req(CMD_TEXT, 8'hFF, 4'h0, 8'h00, 0);
        add_req(CMD_TEXT, 8'h80, 4'h0, 8'h00, 0);
        add_req(CMD_TEXT, 8'h1F, 4'h0, 8'h00, 0);
        add_req(CMD_TEXT, CHAR_LF, 4'hA, 8'h5A, 0);
        add_req(CMD_TEXT, CHAR_CR, 4'h0, 8'h00, 0);
        add_req(CMD_SET_CURSOR, 8'h41, 4'hF, 8'hFF, 0);
        add_req(CMD_TEXT, 8'h7A, 4'h0, 8'h00, 0);
        add_req(CMD_TEXT, CHAR_LF, 4'h0, 8'h00, 0);
        add_req(CMD_SET_CURSOR, 8'h00, 4'h8, 8'h80, 0);
        add_req(CMD_SET_CURSOR, 8'hFF, 4'h0, 8'h00, 0);
        add_req(CMD_SET_CURSOR, 8'h00, 4'h3, 8'(PANEL_WIDTH - GLYPH_ADVANCE), 1);
        add_req(CMD_TEXT, 8'h57, 4'h0, 8'h00, 0);
        add_req(CMD_TEXT, 8'h21, 4'h0, 8'h00, 0);
        add_req(CMD_SET_CURSOR, 8'h00, 4'h5, 8'(PANEL_WIDTH - GLYPH_ADVANCE + 1), 0);
        add_req(CMD_TEXT, 8'h7E, 4'h0, 8'h00, 0);
        add_req(CMD_TEXT, CHAR_NUL, 4'hF, 8'hFF, 0);
        add_req(CMD_SET_CURSOR, 8'hAA, 4'h7, 8'(PANEL_WIDTH - 1), 0);
        add_req(CMD_TEXT, CHAR_CR, 4'h0, 8'h00, 0);
        add_req(CMD_TEXT, 8'h0B, 4'h0, 8'h00, 0);

        // random: mostly printable text so lines fill and wrap
        for (int n = 0; n < RANDOM_REQS; n++) begin
            pick = $urandom_range(99);
            pg   = 4'($urandom_range(15));
            col  = 8'($urandom);
            code = 8'($urandom);
            if (pick < 14) begin
                if (pick < 5) col = 8'(PANEL_WIDTH - 8 + $urandom_range(7));
                add_req(CMD_SET_CURSOR, code, pg, col, n % 80 == 40);
            end else if (pick < 18) begin
                add_req(CMD_TEXT, CHAR_LF, pg, col, n % 80 == 40);
            end else if (pick < 21) begin
                add_req(CMD_TEXT, CHAR_CR, pg, col, n % 80 == 40);
            end else if (pick < 24) begin
                add_req(CMD_TEXT, CHAR_NUL, pg, col, n % 80 == 40);
            end else if (pick < 36) begin
                add_req(CMD_TEXT, code, pg, col, n % 80 == 40);
            end else begin
                add_req(CMD_TEXT, 8'($urandom_range(CHAR_FIRST, CHAR_LAST)), pg, col,
                        n % 80 == 40);
            end
        end
        total_reqs = pending_reqs.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_reqs < total_reqs || expected_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/tgsr_pkg.sv
hdl/tgsr_front.sv
hdl/tgsr_queue.sv
hdl/tgsr_back.sv
hdl/text_glyph_stream_renderer.sv
tb/sv/tb.sv
